// ===== hdl/lge_pkg.sv =====
`timescale 1ns / 1ps

package lge_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int RC_W     = 6;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W = 4;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_KILL  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

  localparam logic [CNT_W-1:0] ROWS_RESET = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(MAX_COLS);

  localparam logic [3:0] LIFE_BIRTH = 4'd3;
  localparam logic [3:0] LIFE_STAY  = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_FINISH,
    S_GEN_PRIME,
    S_GEN_LOAD,
    S_GEN_ROW
  } state_e;

  typedef logic [MAX_COLS-1:0] row_t;

endpackage

// ===== hdl/lge_if.sv =====
`timescale 1ns / 1ps

interface lge_req_if import lge_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [RC_W-1:0] row;
  logic [RC_W-1:0] col;

  modport source (output valid, output opcode, output row, output col, input ready);
  modport sink   (input valid, input opcode, input row, input col, output ready);
endinterface

interface lge_rsp_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic in_range;

  modport source (output valid, output cell_value, output in_range, input ready);
  modport sink   (input valid, input cell_value, input in_range, output ready);
endinterface

interface lge_cfg_if import lge_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lge_ram.sv =====
`timescale 1ns / 1ps

module lge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/lge_row_alu.sv =====
`timescale 1ns / 1ps

module lge_row_alu import lge_pkg::*; (
  input  row_t             prev_i,
  input  row_t             cur_i,
  input  row_t             next_i,
  input  logic [CNT_W-1:0] n_cols_i,
  output row_t             row_o
);

  row_t                mask;
  logic [MAX_COLS+1:0] pp;
  logic [MAX_COLS+1:0] cp;
  logic [MAX_COLS+1:0] np;

  // columns past the grid in use count as dead
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign mask[c] = (CNT_W'(c) < n_cols_i);
  end

  assign pp = {1'b0, prev_i & mask, 1'b0};
  assign cp = {1'b0, cur_i  & mask, 1'b0};
  assign np = {1'b0, next_i & mask, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic [3:0] cnt;
    assign cnt = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2])
               + 4'(cp[c])               + 4'(cp[c+2])
               + 4'(np[c]) + 4'(np[c+1]) + 4'(np[c+2]);
    assign row_o[c] = mask[c] ? ((cnt == LIFE_BIRTH) || (cp[c+1] && cnt == LIFE_STAY))
                              : cur_i[c];
  end

endmodule

// ===== hdl/life_grid_engine_core.sv =====
`timescale 1ns / 1ps
// grid of one-bit life cells held as one memory row per grid row
// in_ch carries requests (opcode, row, col); out_ch returns one result per
// request (cell_value, in_range); cfg_ch writes rows_in_use (index 0) and
// cols_in_use (index 1), always ready; the user must write these only while
// the block is idle, which the block itself does not enforce; set, kill, clear
// and read: an access step reads the row, a write-back step raises the result,
// and the next request is taken back in idle; next generation: skipped when
// the grid in use is empty, else loads rows 0 and 1, then sweeps the rows in
// use (capped at 64) one row per cycle, reading row r+2 while row r is written
// back through the single read and single write port of the row memory
// reset: config goes to 64 by 64, all row valid bits clear at once so the
// whole grid reads dead with no clearing pass; clear all works the same way
// a held result sits in the output register; the next request is taken and
// worked on, and only its final write-back step waits for the register
// to drain
module life_grid_engine_core import lge_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lge_req_if.sink     in_ch,
  lge_rsp_if.source   out_ch,
  lge_cfg_if.sink     cfg_ch
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] rows_q, cols_q;
  logic [CNT_W-1:0] eff_rows, eff_cols;

  logic [OP_W-1:0]  op_q;
  logic [RC_W-1:0]  row_q, col_q;
  logic             inr_q;

  logic [MAX_ROWS-1:0] valid_q;
  logic [ROW_W-1:0]    rd_row_q;
  logic [ROW_W-1:0]    gen_r_q;
  row_t                prev_q, cur_q;

  logic out_valid_q, out_val_q, out_inr_q;

  logic             ram_we, ram_re;
  logic [ROW_W-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata, ram_rdata, rdata_m;
  row_t             alu_row, next_row, mod_row;

  logic in_acc, cfg_acc, req_inr, next_inr, gen_empty;
  logic finish, gen_load, gen_shift, is_write, new_bit;
  logic [COL_W-1:0] col_idx;

  assign eff_rows = (rows_q > ROWS_RESET) ? ROWS_RESET : rows_q;
  assign eff_cols = (cols_q > COLS_RESET) ? COLS_RESET : cols_q;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  assign req_inr   = (CNT_W'(in_ch.row) < eff_rows) && (CNT_W'(in_ch.col) < eff_cols);
  assign gen_empty = (eff_rows == '0) || (eff_cols == '0);

  // rows never written since reset or clear read as dead
  assign rdata_m  = valid_q[rd_row_q] ? ram_rdata : '0;
  assign next_inr = (CNT_W'(gen_r_q) + CNT_W'(1)) < eff_rows;
  assign next_row = next_inr ? rdata_m : '0;

  assign col_idx  = COL_W'(col_q);
  assign is_write = (op_q == OP_SET) || (op_q == OP_KILL);
  assign new_bit  = is_write ? (op_q == OP_SET) : rdata_m[col_idx];

  always_comb begin
    mod_row          = rdata_m;
    mod_row[col_idx] = (op_q == OP_SET);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == OP_STEP && !gen_empty) begin
            state_d = S_GEN_PRIME;
          end else begin
            state_d = S_ACCESS;
          end
        end
      end
      S_ACCESS:    state_d = S_FINISH;
      S_FINISH:    if (finish) state_d = S_IDLE;
      S_GEN_PRIME: state_d = S_GEN_LOAD;
      S_GEN_LOAD:  state_d = S_GEN_ROW;
      S_GEN_ROW:   if (!next_inr) state_d = S_ACCESS;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ROW_W'(row_q);
    ram_raddr = ROW_W'(row_q);
    ram_wdata = mod_row;
    finish    = 1'b0;
    gen_load  = 1'b0;
    gen_shift = 1'b0;
    unique case (state_q)
      S_IDLE: ;
      S_ACCESS: ram_re = 1'b1;
      S_FINISH: begin
        ram_re = 1'b1;
        if (!out_valid_q || out_ch.ready) begin
          finish = 1'b1;
          ram_we = is_write && inr_q;
        end
      end
      S_GEN_PRIME: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_GEN_LOAD: begin
        ram_re    = 1'b1;
        ram_raddr = ROW_W'(1);
        gen_load  = 1'b1;
      end
      S_GEN_ROW: begin
        ram_re    = 1'b1;
        ram_raddr = gen_r_q + ROW_W'(2);
        ram_we    = 1'b1;
        ram_waddr = gen_r_q;
        ram_wdata = alu_row;
        gen_shift = 1'b1;
      end
      default: ;
    endcase
  end

  lge_row_alu u_alu (
    .prev_i   (prev_q),
    .cur_i    (cur_q),
    .next_i   (next_row),
    .n_cols_i (eff_cols),
    .row_o    (alu_row)
  );

  lge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= ROWS_RESET;
      cols_q      <= COLS_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          REG_ROWS: rows_q <= cfg_ch.data;
          REG_COLS: cols_q <= cfg_ch.data;
          default:  ;
        endcase
      end
      if (in_acc && in_ch.opcode == OP_CLEAR) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_ch.opcode;
      row_q <= in_ch.row;
      col_q <= in_ch.col;
      inr_q <= req_inr;
    end
    if (ram_re) begin
      rd_row_q <= ram_raddr;
    end
    if (gen_load) begin
      prev_q  <= '0;
      cur_q   <= rdata_m;
      gen_r_q <= '0;
    end else if (gen_shift) begin
      prev_q  <= cur_q;
      cur_q   <= next_row;
      gen_r_q <= gen_r_q + ROW_W'(1);
    end
    if (finish) begin
      out_val_q <= inr_q && new_bit;
      out_inr_q <= inr_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.cell_value = out_val_q;
  assign out_ch.in_range   = out_inr_q;

  // a generation never writes a row outside the grid in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEN_ROW) |-> (CNT_W'(gen_r_q) < eff_rows))
    else $error("generation wrote outside rows in use");

  // out-of-range set or kill leaves the store untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !inr_q) |-> !ram_we)
    else $error("out-of-range request wrote the store");

  // results only come out of the write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside write-back");

  // clear all empties every row at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_ch.opcode == OP_CLEAR) |=> (valid_q == '0))
    else $error("clear left valid rows");

endmodule
